### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the flash erase sequencer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define FES_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define FES_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`define FES_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);
`else
`define FES_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define FES_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`define FES_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

### src/fes_pkg.sv
// ----------------------------------------------------------------------------
// Flash erase sequencer package
// Field widths, reset values and command codes shared by the sequencer files.
// ----------------------------------------------------------------------------
`default_nettype none

package fes_pkg;

    localparam int unsigned ADDR_W = 24;
    localparam int unsigned BLKS_W = 9;
    localparam int unsigned ID_W   = 32;
    localparam int unsigned MS_W   = 32;

    localparam logic [MS_W-1:0] TIMEOUT_RESET = MS_W'(60 * 1000);

    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FAIL = 1'b1;

    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_POST_ALL = 2'd1,
        OP_POST_BLK = 2'd2,
        OP_NONE     = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_CHIP  = 2'd1,
        KIND_BLOCK = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        PH_READY      = 3'd0,
        PH_CHIP_ISSUE = 3'd1,
        PH_CHIP_WAIT  = 3'd2,
        PH_BLK_ISSUE  = 3'd3,
        PH_BLK_WAIT   = 3'd4
    } t_phase;

endpackage

`default_nettype wire

### src/fes_align.sv
// ----------------------------------------------------------------------------
// Block alignment check
// Two-step test that an address is a multiple of the block size, using a
// reciprocal multiply for the quotient and a multiply-back compare.
// ----------------------------------------------------------------------------
`default_nettype none

module fes_align
    import fes_pkg::*;
#(
    parameter int unsigned BLOCK_BYTES = 65536
) (
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic [ADDR_W-1:0] i_addr,
    input  wire logic [ADDR_W-1:0] i_addr_chk,
    output logic                   o_aligned
);

    localparam int unsigned LOG_B  = $clog2(BLOCK_BYTES);
    localparam int unsigned SH     = ADDR_W + LOG_B;
    localparam int unsigned RW     = ADDR_W + 2;
    localparam int unsigned PW     = ADDR_W + RW;
    localparam int unsigned QW     = ADDR_W + 1 - LOG_B;
    localparam longint unsigned RECIP =
        ((64'd1 << SH) + 64'(BLOCK_BYTES) - 64'd1) / 64'(BLOCK_BYTES);

    logic [PW-1:0]     w_prod;
    logic [QW-1:0]     w_quot;
    logic [QW-1:0]     r_quot;
    logic [ADDR_W:0]   w_back;

    assign w_prod = {RW'(0), i_addr} * PW'(RECIP);
    assign w_quot = QW'(w_prod >> SH);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quot <= w_quot;
        end
    end

    assign w_back    = (ADDR_W + 1)'(r_quot) * (ADDR_W + 1)'(BLOCK_BYTES);
    assign o_aligned = (w_back == {1'b0, i_addr_chk});

endmodule

`default_nettype wire

### src/flash_erase_sequencer.sv
// ----------------------------------------------------------------------------
// Flash erase sequencer
// Stores chip or multi-block erase requests and steps the erase sequence one
// tick word at a time, reporting issued commands and completion status.
// ----------------------------------------------------------------------------
//   Channel   Handshake                 Contents
//   input     i_in_valid / o_in_ready   opcode, request fields, tick inputs
//   output    o_out_valid / i_out_ready one result word per input word
//   config    i_cfg_we                  timeout in milliseconds
//
// Each word passes three register stages: input capture, alignment quotient,
// then the sequencer state update with the result register.
// One word is accepted per cycle while the result channel does not stall;
// o_out_valid rises when the word reaches the result register.
// A stalled result holds the stages behind it; empty stages still fill.
// Reset is synchronous and active low and returns the sequencer to ready.
`default_nettype none
`include "assert_macros.svh"

module flash_erase_sequencer
    import fes_pkg::*;
#(
    parameter int unsigned BLOCK_BYTES = 65536,
    parameter int unsigned ADDR_BITS   = 24,
    parameter int unsigned MAX_BLOCKS  = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [MS_W-1:0]          i_cfg_wdata,
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire logic [1:0]               i_opcode,
    input  wire logic [ADDR_W-1:0]        i_req_addr,
    input  wire logic [BLKS_W-1:0]        i_req_blocks,
    input  wire logic signed [ID_W-1:0]   i_req_id,
    input  wire logic                     i_cmd_ok,
    input  wire logic                     i_device_done,
    input  wire logic [MS_W-1:0]          i_now_ms,
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output logic                          o_post_accepted,
    output logic [1:0]                    o_issue_kind,
    output logic [ADDR_W-1:0]             o_issue_addr,
    output logic                          o_finished,
    output logic                          o_finish_status,
    output logic signed [ID_W-1:0]        o_finish_id
);

    localparam logic [32:0] ADDR_MASK = (33'd1 << ADDR_BITS) - 33'd1;

    logic                     r_s1_valid;
    t_opcode                  r_s1_op;
    logic [ADDR_W-1:0]        r_s1_addr;
    logic [BLKS_W-1:0]        r_s1_blocks;
    logic signed [ID_W-1:0]   r_s1_id;
    logic                     r_s1_cmd_ok;
    logic                     r_s1_done;
    logic [MS_W-1:0]          r_s1_now;

    logic                     r_s2_valid;
    t_opcode                  r_s2_op;
    logic [ADDR_W-1:0]        r_s2_addr;
    logic [BLKS_W-1:0]        r_s2_blocks;
    logic signed [ID_W-1:0]   r_s2_id;
    logic                     r_s2_cmd_ok;
    logic                     r_s2_done;
    logic [MS_W-1:0]          r_s2_now;

    logic                     r_out_valid;
    logic                     r_post_acc;
    t_kind                    r_issue_kind;
    logic [ADDR_W-1:0]        r_issue_addr;
    logic                     r_finished;
    logic                     r_status;
    logic signed [ID_W-1:0]   r_finish_id;

    logic [MS_W-1:0]          r_timeout;
    t_phase                   r_phase;
    t_kind                    r_pend;
    logic [ADDR_W-1:0]        r_base;
    logic [BLKS_W-1:0]        r_total;
    logic signed [ID_W-1:0]   r_token;
    logic [BLKS_W-1:0]        r_done_cnt;
    logic [MS_W-1:0]          r_wait;

    t_phase                   n_phase;
    t_kind                    n_pend;
    logic [ADDR_W-1:0]        n_base;
    logic [BLKS_W-1:0]        n_total;
    logic signed [ID_W-1:0]   n_token;
    logic [BLKS_W-1:0]        n_done_cnt;
    logic [MS_W-1:0]          n_wait;
    logic                     n_post_acc;
    t_kind                    n_issue_kind;
    logic [ADDR_W-1:0]        n_issue_addr;
    logic                     n_finished;
    logic                     n_status;
    logic signed [ID_W-1:0]   n_finish_id;

    logic                     w_out_free;
    logic                     w_s2_free;
    logic                     w_s2_adv;
    logic                     w_s1_free;
    logic                     w_aligned;
    logic                     w_blk_ok;
    logic                     w_active;
    logic [BLKS_W-1:0]        w_cnt_eff;
    logic [BLKS_W-1:0]        w_cnt_inc;
    logic [31:0]              w_blk_off;
    logic [31:0]              w_blk_sum;
    logic [31:0]              w_blk_addr;
    logic [MS_W-1:0]          w_elapsed;
    logic                     w_timeout;

    // Each stage can take a word when it is empty or its word moves on.
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_s2_free  = !r_s2_valid || w_out_free;
    assign w_s2_adv   = r_s2_valid && w_out_free;
    assign w_s1_free  = !r_s1_valid || w_s2_free;
    assign o_in_ready = w_s1_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_s1_free) begin
                r_s1_valid <= i_in_valid;
            end
            if (w_s2_free) begin
                r_s2_valid <= r_s1_valid;
            end
            if (w_out_free) begin
                r_out_valid <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_free && i_in_valid) begin
            r_s1_op     <= t_opcode'(i_opcode);
            r_s1_addr   <= i_req_addr;
            r_s1_blocks <= i_req_blocks;
            r_s1_id     <= i_req_id;
            r_s1_cmd_ok <= i_cmd_ok;
            r_s1_done   <= i_device_done;
            r_s1_now    <= i_now_ms;
        end
        if (w_s2_free && r_s1_valid) begin
            r_s2_op     <= r_s1_op;
            r_s2_addr   <= r_s1_addr;
            r_s2_blocks <= r_s1_blocks;
            r_s2_id     <= r_s1_id;
            r_s2_cmd_ok <= r_s1_cmd_ok;
            r_s2_done   <= r_s1_done;
            r_s2_now    <= r_s1_now;
        end
        if (w_s2_adv) begin
            r_post_acc   <= n_post_acc;
            r_issue_kind <= n_issue_kind;
            r_issue_addr <= n_issue_addr;
            r_finished   <= n_finished;
            r_status     <= n_status;
            r_finish_id  <= n_finish_id;
        end
    end

    fes_align #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_align (
        .i_clk      (i_clk),
        .i_en       (w_s2_free && r_s1_valid),
        .i_addr     (r_s1_addr),
        .i_addr_chk (r_s2_addr),
        .o_aligned  (w_aligned)
    );

    assign w_blk_ok = w_aligned && (r_s2_blocks != '0) &&
                      (17'(r_s2_blocks) <= 17'(MAX_BLOCKS));

    assign w_active  = (r_phase == PH_CHIP_ISSUE) || (r_phase == PH_CHIP_WAIT) ||
                       (r_phase == PH_BLK_ISSUE) || (r_phase == PH_BLK_WAIT);
    assign w_cnt_eff = w_active ? r_done_cnt : '0;
    assign w_cnt_inc = w_cnt_eff + BLKS_W'(1);
    assign w_blk_off = 32'(w_cnt_eff) * 32'(BLOCK_BYTES);
    assign w_blk_sum = 32'(r_base) + w_blk_off;
    assign w_blk_addr = w_blk_sum & ADDR_MASK[31:0];
    assign w_elapsed = r_s2_now - r_wait;
    assign w_timeout = (w_elapsed > r_timeout);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            r_timeout <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_READY;
            r_pend     <= KIND_NONE;
            r_base     <= '0;
            r_total    <= '0;
            r_token    <= '0;
            r_done_cnt <= '0;
            r_wait     <= '0;
        end else if (w_s2_adv) begin
            r_phase    <= n_phase;
            r_pend     <= n_pend;
            r_base     <= n_base;
            r_total    <= n_total;
            r_token    <= n_token;
            r_done_cnt <= n_done_cnt;
            r_wait     <= n_wait;
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_pend       = r_pend;
        n_base       = r_base;
        n_total      = r_total;
        n_token      = r_token;
        n_done_cnt   = r_done_cnt;
        n_wait       = r_wait;
        n_post_acc   = 1'b0;
        n_issue_kind = KIND_NONE;
        n_issue_addr = '0;
        n_finished   = 1'b0;
        n_status     = ST_OK;
        n_finish_id  = '0;
        unique case (r_s2_op)
            OP_POST_ALL: begin
                n_pend     = KIND_CHIP;
                n_token    = r_s2_id;
                n_post_acc = 1'b1;
            end
            OP_POST_BLK: begin
                if (w_blk_ok) begin
                    n_pend     = KIND_BLOCK;
                    n_base     = r_s2_addr;
                    n_total    = r_s2_blocks;
                    n_token    = r_s2_id;
                    n_post_acc = 1'b1;
                end
            end
            OP_TICK: begin
                // A ready sequencer first picks up whatever request is stored.
                unique case (r_phase)
                    PH_CHIP_ISSUE, PH_CHIP_WAIT, PH_BLK_ISSUE, PH_BLK_WAIT: begin
                        n_phase = r_phase;
                    end
                    default: begin
                        if (r_pend == KIND_CHIP) begin
                            n_phase = PH_CHIP_ISSUE;
                        end else if (r_pend == KIND_BLOCK) begin
                            n_done_cnt = '0;
                            n_phase    = PH_BLK_ISSUE;
                        end else begin
                            n_phase = PH_READY;
                        end
                    end
                endcase
                unique case (n_phase)
                    PH_CHIP_ISSUE, PH_BLK_ISSUE: begin
                        if (r_s2_cmd_ok) begin
                            n_wait = r_s2_now;
                            if (n_phase == PH_CHIP_ISSUE) begin
                                n_issue_kind = KIND_CHIP;
                                n_phase      = PH_CHIP_WAIT;
                            end else begin
                                n_issue_kind = KIND_BLOCK;
                                n_issue_addr = w_blk_addr[ADDR_W-1:0];
                                n_phase      = PH_BLK_WAIT;
                            end
                        end else begin
                            n_finished  = 1'b1;
                            n_status    = ST_FAIL;
                            n_finish_id = r_token;
                            n_phase     = PH_READY;
                            n_pend      = KIND_NONE;
                        end
                    end
                    PH_CHIP_WAIT, PH_BLK_WAIT: begin
                        if (r_s2_done) begin
                            if (n_phase == PH_BLK_WAIT) begin
                                n_done_cnt = w_cnt_inc;
                            end
                            if (n_phase == PH_CHIP_WAIT || r_total <= w_cnt_inc) begin
                                n_finished  = 1'b1;
                                n_status    = ST_OK;
                                n_finish_id = r_token;
                                n_phase     = PH_READY;
                                n_pend      = KIND_NONE;
                            end else begin
                                n_phase = PH_BLK_ISSUE;
                            end
                        end else if (w_timeout) begin
                            n_finished  = 1'b1;
                            n_status    = ST_FAIL;
                            n_finish_id = r_token;
                            n_phase     = PH_READY;
                            n_pend      = KIND_NONE;
                        end
                    end
                    default: begin
                        n_phase = PH_READY;
                    end
                endcase
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
    end

    assign o_out_valid     = r_out_valid;
    assign o_post_accepted = r_post_acc;
    assign o_issue_kind    = r_issue_kind;
    assign o_issue_addr    = r_issue_addr;
    assign o_finished      = r_finished;
    assign o_finish_status = r_status;
    assign o_finish_id     = r_finish_id;

    `FES_ASSERT_IMP(a_wait_has_req, i_clk, i_rst_n, (r_phase == PH_CHIP_WAIT || r_phase == PH_BLK_WAIT), (r_pend != KIND_NONE), "Waiting phase without a stored request.")
    `FES_ASSERT_NXT(a_finish_to_ready, i_clk, i_rst_n, (w_s2_adv && n_finished), (r_phase == PH_READY && r_pend == KIND_NONE), "Finish did not return to ready.")
    `FES_ASSERT_NXT(a_chip_issue_wait, i_clk, i_rst_n, (w_s2_adv && n_issue_kind == KIND_CHIP), (r_phase == PH_CHIP_WAIT), "Chip erase issue did not enter the wait phase.")
    `FES_ASSERT_NEVER(a_post_excl, i_clk, i_rst_n, (r_out_valid && r_post_acc && (r_finished || r_issue_kind != KIND_NONE)), "Post result also reports sequence activity.")
    `FES_ASSERT_IMP(a_stall_full, i_clk, i_rst_n, (!o_in_ready), (r_s1_valid && r_s2_valid && r_out_valid && !i_out_ready), "Input stalled while the pipeline has room.")

endmodule

`default_nettype wire

### sim/flash_erase_sequencer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Flash erase sequencer testbench
// Sends post and tick words through the valid/ready input channel and checks
// every result word against an erase-sequence predictor kept in the bench.
// A directed run covers request rejection, address wrap, overwrites during a
// sequence, command failure and the timeout boundary. Random runs at several
// timeout settings follow, with idle gaps and stalls on both channels.
// ----------------------------------------------------------------------------

module flash_erase_sequencer_tb;
    import fes_pkg::*;

    localparam int unsigned BLOCK_BYTES = 65536;
    localparam int unsigned ADDR_BITS   = 24;
    localparam int unsigned MAX_BLOCKS  = 256;

    typedef struct packed {
        t_opcode           op;
        logic [ADDR_W-1:0] addr;
        logic [BLKS_W-1:0] blocks;
        logic [ID_W-1:0]   id;
        logic              cmd_ok;
        logic              done;
        logic [MS_W-1:0]   now;
    } erase_word_t;

    typedef struct packed {
        logic              accepted;
        t_kind             kind;
        logic [ADDR_W-1:0] addr;
        logic              finished;
        logic              status;
        logic [ID_W-1:0]   id;
    } erase_result_t;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [MS_W-1:0]        i_cfg_wdata = '0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_ready;
    logic [1:0]             i_opcode = '0;
    logic [ADDR_W-1:0]      i_req_addr = '0;
    logic [BLKS_W-1:0]      i_req_blocks = '0;
    logic signed [ID_W-1:0] i_req_id = '0;
    logic                   i_cmd_ok = 1'b0;
    logic                   i_device_done = 1'b0;
    logic [MS_W-1:0]        i_now_ms = '0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    logic                   o_post_accepted;
    logic [1:0]             o_issue_kind;
    logic [ADDR_W-1:0]      o_issue_addr;
    logic                   o_finished;
    logic                   o_finish_status;
    logic signed [ID_W-1:0] o_finish_id;

    // Predictor state.
    t_phase              seq_phase = PH_READY;
    t_kind               pend_kind = KIND_NONE;
    logic [ADDR_W-1:0]   base_addr_m = '0;
    logic [BLKS_W-1:0]   blk_total = '0;
    logic [ID_W-1:0]     token = '0;
    logic [16:0]         blks_done = '0;
    logic [MS_W-1:0]     wait_t0 = '0;
    logic [MS_W-1:0]     timeout_ms_m = TIMEOUT_RESET;

    erase_word_t         tx_words[$];
    erase_result_t       due_results[$];
    erase_word_t         cur_word;
    erase_result_t       want;
    erase_result_t       got;
    int                  words_made = 0;
    int                  mismatch_cnt = 0;
    int                  gap_left = 0;
    int                  sink_wait = 0;
    int                  hold_left = 0;
    bit                  hold_go = 1'b0;
    bit                  hold_spent = 1'b0;
    bit                  src_idle_en = 1'b1;
    bit                  sink_idle_en = 1'b1;
    logic [MS_W-1:0]     ms_clock = '0;

    flash_erase_sequencer #(
        .BLOCK_BYTES(BLOCK_BYTES),
        .ADDR_BITS  (ADDR_BITS),
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_opcode       (i_opcode),
        .i_req_addr     (i_req_addr),
        .i_req_blocks   (i_req_blocks),
        .i_req_id       (i_req_id),
        .i_cmd_ok       (i_cmd_ok),
        .i_device_done  (i_device_done),
        .i_now_ms       (i_now_ms),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_post_accepted(o_post_accepted),
        .o_issue_kind   (o_issue_kind),
        .o_issue_addr   (o_issue_addr),
        .o_finished     (o_finished),
        .o_finish_status(o_finish_status),
        .o_finish_id    (o_finish_id)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic erase_result_t erase_step(input erase_word_t w);
        erase_result_t r;
        logic          end_req;
        logic          end_st;
        r = '0;
        end_req = 1'b0;
        end_st = ST_OK;
        case (w.op)
            OP_POST_ALL: begin
                pend_kind = KIND_CHIP;
                token = w.id;
                r.accepted = 1'b1;
            end
            OP_POST_BLK: begin
                if ((w.addr % BLOCK_BYTES) == 0 && w.blocks >= 1 && w.blocks <= MAX_BLOCKS) begin
                    pend_kind = KIND_BLOCK;
                    base_addr_m = w.addr;
                    blk_total = w.blocks;
                    token = w.id;
                    r.accepted = 1'b1;
                end
            end
            OP_TICK: begin
                if (seq_phase == PH_READY) begin
                    if (pend_kind == KIND_CHIP) begin
                        seq_phase = PH_CHIP_ISSUE;
                    end else if (pend_kind == KIND_BLOCK) begin
                        blks_done = '0;
                        seq_phase = PH_BLK_ISSUE;
                    end
                end
                case (seq_phase)
                    PH_CHIP_ISSUE, PH_BLK_ISSUE: begin
                        if (w.cmd_ok) begin
                            if (seq_phase == PH_CHIP_ISSUE) begin
                                r.kind = KIND_CHIP;
                                seq_phase = PH_CHIP_WAIT;
                            end else begin
                                r.kind = KIND_BLOCK;
                                r.addr = ADDR_W'(base_addr_m + blks_done * BLOCK_BYTES);
                                seq_phase = PH_BLK_WAIT;
                            end
                            wait_t0 = w.now;
                        end else begin
                            end_req = 1'b1;
                            end_st = ST_FAIL;
                        end
                    end
                    PH_CHIP_WAIT, PH_BLK_WAIT: begin
                        if (w.done) begin
                            if (seq_phase == PH_CHIP_WAIT) begin
                                end_req = 1'b1;
                            end else begin
                                blks_done = blks_done + 1'b1;
                                if (blk_total <= blks_done) end_req = 1'b1;
                                else seq_phase = PH_BLK_ISSUE;
                            end
                        end else if (MS_W'(w.now - wait_t0) > timeout_ms_m) begin
                            end_req = 1'b1;
                            end_st = ST_FAIL;
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        if (end_req) begin
            r.finished = 1'b1;
            r.status = end_st;
            r.id = token;
            seq_phase = PH_READY;
            pend_kind = KIND_NONE;
        end
        return r;
    endfunction

    // Input side: one word in flight on the port, gaps drawn per word.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) due_results.push_back(erase_step(cur_word));
            if (!i_in_valid || o_in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (tx_words.size() > 0) begin
                    cur_word = tx_words.pop_front();
                    i_opcode <= cur_word.op;
                    i_req_addr <= cur_word.addr;
                    i_req_blocks <= cur_word.blocks;
                    i_req_id <= cur_word.id;
                    i_cmd_ok <= cur_word.cmd_ok;
                    i_device_done <= cur_word.done;
                    i_now_ms <= cur_word.now;
                    i_in_valid <= 1'b1;
                    gap_left = src_idle_en ? $urandom_range(0, 19) : 0;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic flag_mismatch(input string what, input erase_result_t w,
                                 input erase_result_t g);
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
            $display("%s at %0t: want acc=%0b kind=%0d addr=%h fin=%0b st=%0b id=%h",
                     what, $realtime, w.accepted, w.kind, w.addr, w.finished, w.status, w.id);
            $display("    got acc=%0b kind=%0d addr=%h fin=%0b st=%0b id=%h",
                     g.accepted, g.kind, g.addr, g.finished, g.status, g.id);
        end
    endtask

    // Output side: result check and receiver stalls.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                got.accepted = o_post_accepted;
                got.kind = t_kind'(o_issue_kind);
                got.addr = o_issue_addr;
                got.finished = o_finished;
                got.status = o_finish_status;
                got.id = o_finish_id;
                if (due_results.size() == 0) begin
                    flag_mismatch("unexpected result", '0, got);
                end else begin
                    want = due_results.pop_front();
                    if (got !== want) flag_mismatch("result mismatch", want, got);
                end
                sink_wait = (sink_idle_en && $urandom_range(0, 1)) ? $urandom_range(0, 19) : 0;
            end else if (sink_wait > 0) begin
                sink_wait--;
            end
            i_out_ready <= (sink_wait == 0) && (hold_left == 0);
        end
    end

    always @(posedge i_clk) begin
        if (hold_go && !hold_spent) begin
            hold_left <= 300;
            hold_spent <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    function automatic erase_word_t random_word();
        erase_word_t w;
        w.op = t_opcode'($urandom_range(0, 3));
        w.addr = ADDR_W'($urandom);
        w.blocks = BLKS_W'($urandom);
        w.id = $urandom;
        w.cmd_ok = $urandom_range(0, 1);
        w.done = $urandom_range(0, 1);
        w.now = $urandom;
        return w;
    endfunction

    task automatic push_word(input erase_word_t w);
        tx_words.push_back(w);
        words_made++;
    endtask

    task automatic put(input t_opcode op, input logic [ADDR_W-1:0] a,
                       input logic [BLKS_W-1:0] b, input logic [ID_W-1:0] id,
                       input logic c, input logic d, input logic [MS_W-1:0] n);
        erase_word_t w;
        w = '{op: op, addr: a, blocks: b, id: id, cmd_ok: c, done: d, now: n};
        push_word(w);
    endtask

    // A well-formed request followed by its issue and wait ticks, with some
    // noise words, command failures and timeouts mixed in.
    task automatic add_sequence();
        erase_word_t     w;
        int unsigned     nblk;
        int unsigned     lim;
        int unsigned     pick;
        logic [MS_W-1:0] t0;
        w = random_word();
        pick = $urandom_range(0, 15);
        if (pick < 5) begin
            w.op = OP_POST_ALL;
            nblk = 1;
        end else begin
            w.op = OP_POST_BLK;
            w.addr = {8'($urandom_range(0, 255)), 16'h0000};
            if (pick == 15) w.blocks = BLKS_W'(MAX_BLOCKS);
            else if (pick == 14) w.blocks = BLKS_W'($urandom_range(4, MAX_BLOCKS));
            else w.blocks = BLKS_W'($urandom_range(1, 3));
            nblk = w.blocks;
        end
        push_word(w);
        lim = (timeout_ms_m < 1000) ? timeout_ms_m : 1000;
        for (int b = 0; b < nblk; b++) begin
            ms_clock += $urandom_range(0, 50);
            w = random_word();
            w.op = OP_TICK;
            w.cmd_ok = (b < 4) && ($urandom_range(0, 15) != 0);
            w.now = ms_clock;
            push_word(w);
            if (!w.cmd_ok) break;
            t0 = ms_clock;
            repeat ($urandom_range(0, 3)) begin
                w = random_word();
                if ($urandom_range(0, 9) != 0) begin
                    w.op = OP_TICK;
                    w.done = 1'b0;
                    w.now = t0 + $urandom_range(0, lim);
                end
                push_word(w);
            end
            w = random_word();
            w.op = OP_TICK;
            pick = $urandom_range(0, 15);
            if (pick < 2) begin
                w.done = 1'b0;
                w.now = t0 + timeout_ms_m + 1 + $urandom_range(0, 3);
            end else begin
                if (pick == 2) begin
                    w.done = 1'b0;
                    w.now = t0 + timeout_ms_m;
                    push_word(w);
                    w = random_word();
                    w.op = OP_TICK;
                end
                w.done = 1'b1;
                w.now = t0 + $urandom_range(0, lim);
            end
            push_word(w);
            ms_clock = w.now;
            if (!w.done) break;
        end
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (tx_words.size() != 0 || i_in_valid || due_results.size() != 0);
    endtask

    task automatic write_timeout(input logic [MS_W-1:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        timeout_ms_m = v;
    endtask

    initial begin
        logic [MS_W-1:0] settings[5];
        int              target;
        settings = '{32'd1, 32'hFFFF_FFFF, MS_W'($urandom_range(2, 200)), MS_W'($urandom),
                     TIMEOUT_RESET};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        put(OP_TICK,     24'h000000, 9'd0,   32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000);
        put(OP_NONE,     24'hFFFFFF, 9'h1FF, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF);
        put(OP_POST_BLK, 24'h010001, 9'd1,   32'h0000_0001, 1'b0, 1'b0, 32'h0000_0000);
        put(OP_POST_BLK, 24'h020000, 9'd0,   32'h0000_0002, 1'b0, 1'b0, 32'h0000_0000);
        put(OP_POST_BLK, 24'h020000, 9'd257, 32'h0000_0003, 1'b0, 1'b0, 32'h0000_0000);
        put(OP_POST_BLK, 24'h008000, 9'd511, 32'h0000_0004, 1'b0, 1'b0, 32'h0000_0000);
        put(OP_POST_BLK, 24'hFF0000, 9'd2,   32'h8000_0000, 1'b0, 1'b0, 32'h0000_0000);
        put(OP_TICK,     24'h000000, 9'd0,   32'h0000_0000, 1'b1, 1'b0, 32'hFFFF_FFF0);
        put(OP_TICK,     24'h000000, 9'd0,   32'h0000_0000, 1'b0, 1'b0, 32'd59984);
        put(OP_TICK,     24'h000000, 9'd0,   32'h0000_0000, 1'b0, 1'b1, 32'd59984);
        put(OP_TICK,     24'h000000, 9'd0,   32'h0000_0000, 1'b1, 1'b0, 32'd60000);
        put(OP_TICK,     24'h000000, 9'd0,   32'h0000_0000, 1'b0, 1'b1, 32'd60010);
        put(OP_POST_ALL, 24'h000000, 9'd0,   32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0000_0000);
        put(OP_TICK,     24'h000000, 9'd0,   32'h0000_0000, 1'b0, 1'b1, 32'd60020);
        put(OP_POST_ALL, 24'h000000, 9'd0,   32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0000_0000);
        put(OP_TICK,     24'h000000, 9'd0,   32'h0000_0000, 1'b1, 1'b0, 32'd1000);
        put(OP_TICK,     24'h000000, 9'd0,   32'h0000_0000, 1'b1, 1'b0, 32'd61001);
        put(OP_POST_BLK, 24'h000000, 9'd256, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000);
        put(OP_TICK,     24'h000000, 9'd0,   32'h0000_0000, 1'b1, 1'b0, 32'd5);
        put(OP_POST_ALL, 24'h000000, 9'd0,   32'h0000_0005, 1'b0, 1'b0, 32'h0000_0000);
        put(OP_TICK,     24'h000000, 9'd0,   32'h0000_0000, 1'b0, 1'b1, 32'd6);
        put(OP_POST_BLK, 24'h100000, 9'd1,   32'h0000_0006, 1'b0, 1'b0, 32'h0000_0000);
        put(OP_TICK,     24'h000000, 9'd0,   32'h0000_0000, 1'b1, 1'b0, 32'd7);
        put(OP_TICK,     24'h000000, 9'd0,   32'h0000_0000, 1'b0, 1'b1, 32'd8);
        put(OP_TICK,     24'h000000, 9'd0,   32'h0000_0000, 1'b1, 1'b1, 32'd9);

        target = words_made;
        for (int p = 0; p < 5; p++) begin
            wait_drained();
            repeat (8) @(posedge i_clk);
            write_timeout(settings[p]);
            src_idle_en = (p != 2) && (p != 3);
            sink_idle_en = (p != 1) && (p != 3);
            ms_clock = (p == 1) ? 32'hFFFF_FF00 : $urandom;
            if (p == 2) hold_go = 1'b1;
            target += 140;
            while (words_made < target) begin
                if ($urandom_range(0, 6) == 0) push_word(random_word());
                else add_sequence();
            end
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (mismatch_cnt == 0 && due_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

endmodule
